@@ rtl/core/bmmpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bmmpc_pkg
// Shared types and constants of the bus mailbox with motor pulse counters.
// ----------------------------------------------------------------------------
package bmmpc_pkg;

    // Buffer geometry.
    localparam int BUFFER_BYTES = 8;
    localparam int IDX_BITS     = $clog2(BUFFER_BYTES);
    localparam int POS_BITS     = $clog2(BUFFER_BYTES + 1);

    // Counter and limit geometry.
    localparam int COUNT_BITS     = 16;
    localparam int LIMIT_BITS     = 16;
    localparam int NUM_CHAN       = 4;
    localparam int CHAN_BITS      = 2;
    localparam int CMP_W          = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
    localparam int CFG_IDX_BITS   = 3;
    localparam int LIMIT_IDX_BITS = 2;

    // Reset values of the pulse limits, channel 0 in the low slot.
    localparam logic [NUM_CHAN-1:0][LIMIT_BITS-1:0] LIMIT_RESET =
        {16'd10, 16'd10, 16'd5, 16'd5};

    // Bus request codes.
    localparam logic [2:0] REQ_WRITE_START = 3'd0;
    localparam logic [2:0] REQ_WRITE_BYTE  = 3'd1;
    localparam logic [2:0] REQ_STOP        = 3'd2;
    localparam logic [2:0] REQ_READ_START  = 3'd3;
    localparam logic [2:0] REQ_READ_NEXT   = 3'd4;
    localparam logic [2:0] REQ_READ_DONE   = 3'd5;
    localparam logic [2:0] REQ_PULSE       = 3'd6;

    // Direction command codes held in command bytes 4 to 7.
    localparam logic [7:0] DIR_STOP = 8'h00;
    localparam logic [7:0] DIR_UP   = 8'h01;
    localparam logic [7:0] DIR_DOWN = 8'h02;
    localparam logic [7:0] DIR_HOLD = 8'h03;

    typedef struct packed {
        logic [2:0]           req_type;
        logic [7:0]           data_byte;
        logic [CHAN_BITS-1:0] channel;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       ack;
        logic       request_asserted;
        logic [7:0] duty_a;
        logic [7:0] duty_b;
        logic [7:0] duty_c;
        logic [7:0] duty_d;
    } t_out_item;

    // Buffer side to counter side: snapshot strobe and direction commands.
    typedef struct packed {
        logic                      snapshot;
        logic [NUM_CHAN-1:0][7:0]  dir;
    } t_buf_ctl;

    // Counter side to buffer side: snapshot values, with channels 2 and 3 shifted.
    typedef logic [NUM_CHAN-1:0][CMP_W-1:0] t_snap_view;

endpackage

@@ rtl/core/bmmpc_counters.sv @@
// ----------------------------------------------------------------------------
// bmmpc_counters
// Pulse limits, the four channel pulse counters and the attention request.
// ----------------------------------------------------------------------------
module bmmpc_counters import bmmpc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [LIMIT_BITS-1:0]   i_cfg_data,
    input  logic                    i_fire,
    input  t_in_item                i_item,
    input  t_buf_ctl                i_ctl,
    output t_snap_view              o_view,
    output logic                    o_req_next
);

    logic [NUM_CHAN-1:0][LIMIT_BITS-1:0] r_limit;
    logic [NUM_CHAN-1:0][COUNT_BITS-1:0] r_cnt;
    logic [NUM_CHAN-1:0][COUNT_BITS-1:0] n_cnt;
    logic                                r_req;
    logic                                n_req;

    logic [COUNT_BITS-1:0] w_sel;
    logic [COUNT_BITS-1:0] w_step;
    logic [7:0]            w_dir;
    logic [CMP_W-1:0]      w_cmp_cnt;
    logic [CMP_W-1:0]      w_cmp_lim;

    // Limit registers are written from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_BITS'(NUM_CHAN))) begin
            r_limit[i_cfg_idx[LIMIT_IDX_BITS-1:0]] <= i_cfg_data;
        end
    end

    // Snapshot view: channels 2 and 3 are halved twice before they are copied.
    always_comb begin
        o_view[0] = CMP_W'(r_cnt[0]);
        o_view[1] = CMP_W'(r_cnt[1]);
        o_view[2] = CMP_W'(r_cnt[2] >> 2);
        o_view[3] = CMP_W'(r_cnt[3] >> 2);
    end

    // Stepped value of the channel that pulsed.
    always_comb begin
        w_sel = r_cnt[i_item.channel];
        w_dir = i_ctl.dir[i_item.channel];
        if (w_dir == DIR_UP) begin
            w_step = w_sel + COUNT_BITS'(1);
        end else if (w_dir == DIR_DOWN) begin
            w_step = w_sel - COUNT_BITS'(1);
        end else begin
            w_step = w_sel;
        end
        w_cmp_cnt = CMP_W'(w_step);
        w_cmp_lim = CMP_W'(r_limit[i_item.channel]);
    end

    // Next counter and request state.
    always_comb begin
        n_cnt = r_cnt;
        n_req = r_req;
        if (i_fire && i_ctl.snapshot) begin
            n_cnt[2] = r_cnt[2] >> 2;
            n_cnt[3] = r_cnt[3] >> 2;
        end
        if (i_fire && (i_item.req_type == REQ_PULSE)) begin
            n_cnt[i_item.channel] = w_step;
            if ((w_dir == DIR_HOLD) || (w_dir == DIR_STOP)) begin
                n_req = 1'b0;
            end
            if ((w_cmp_cnt > w_cmp_lim) && (w_dir == DIR_UP)) begin
                n_req = 1'b1;
            end
            if ((w_cmp_cnt < w_cmp_lim) && (w_dir == DIR_DOWN)) begin
                n_req = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_req <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_req <= n_req;
        end
    end

    assign o_req_next = n_req;

endmodule

@@ rtl/core/bmmpc_buffers.sv @@
// ----------------------------------------------------------------------------
// bmmpc_buffers
// Command and reply byte stores with their write and read positions.
// ----------------------------------------------------------------------------
module bmmpc_buffers import bmmpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_in_item         i_item,
    input  t_snap_view       i_view,
    output t_buf_ctl         o_ctl,
    output logic [7:0]       o_read_byte,
    output logic             o_ack,
    output logic [3:0][7:0]  o_duty
);

    logic [BUFFER_BYTES-1:0][7:0] r_cmd;
    logic [BUFFER_BYTES-1:0][7:0] n_cmd;
    logic [BUFFER_BYTES-1:0][7:0] r_reply;
    logic [BUFFER_BYTES-1:0][7:0] n_reply;
    logic [POS_BITS-1:0]          r_wpos;
    logic [POS_BITS-1:0]          n_wpos;
    logic [POS_BITS-1:0]          r_rpos;
    logic [POS_BITS-1:0]          n_rpos;
    logic                         r_pend;
    logic                         n_pend;
    logic                         w_snap;

    // A snapshot is taken on the first read-next byte of a read.
    assign w_snap = (i_item.req_type == REQ_READ_NEXT) && r_pend;

    always_comb begin
        o_ctl.snapshot = i_fire && w_snap;
        for (int d = 0; d < NUM_CHAN; d++) begin
            o_ctl.dir[d] = r_cmd[NUM_CHAN + d];
        end
    end

    // Reply store as it stands after a possible snapshot.
    always_comb begin
        n_reply = r_reply;
        if (w_snap) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                n_reply[2 * c]     = i_view[c][7:0];
                n_reply[2 * c + 1] = i_view[c][15:8];
            end
        end
    end

    // Request decode: positions, stores, offered byte and acknowledge.
    always_comb begin
        n_cmd       = r_cmd;
        n_wpos      = r_wpos;
        n_rpos      = r_rpos;
        n_pend      = r_pend;
        o_read_byte = 8'h00;
        o_ack       = 1'b0;
        unique case (i_item.req_type)
            REQ_WRITE_START: begin
                n_wpos = '0;
                o_ack  = 1'b1;
            end
            REQ_WRITE_BYTE: begin
                if (r_wpos < POS_BITS'(BUFFER_BYTES)) begin
                    n_cmd[r_wpos[IDX_BITS-1:0]] = i_item.data_byte;
                    n_wpos = r_wpos + POS_BITS'(1);
                end
                o_ack = 1'b1;
            end
            REQ_STOP: begin
                o_ack = 1'b1;
            end
            REQ_READ_START: begin
                o_read_byte = r_reply[0];
                n_rpos      = POS_BITS'(1);
                o_ack       = 1'b1;
            end
            REQ_READ_NEXT: begin
                n_pend = 1'b0;
                if (r_rpos < POS_BITS'(BUFFER_BYTES)) begin
                    o_read_byte = n_reply[r_rpos[IDX_BITS-1:0]];
                    n_rpos      = r_rpos + POS_BITS'(1);
                    o_ack       = (n_rpos != POS_BITS'(BUFFER_BYTES));
                end
            end
            REQ_READ_DONE: begin
                n_pend = 1'b1;
                o_ack  = 1'b1;
            end
            default: begin
                // Pulse events and the unused code leave the buffers alone.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= '0;
            r_reply <= '0;
            r_wpos  <= '0;
            r_rpos  <= '0;
            r_pend  <= 1'b1;
        end else if (i_fire) begin
            r_cmd   <= n_cmd;
            r_reply <= n_reply;
            r_wpos  <= n_wpos;
            r_rpos  <= n_rpos;
            r_pend  <= n_pend;
        end
    end

    // Duty values reflect the command store after this request.
    always_comb begin
        for (int d = 0; d < 4; d++) begin
            o_duty[d] = i_fire ? n_cmd[d] : r_cmd[d];
        end
    end

endmodule

@@ rtl/core/bus_mailbox_motor_pulse_counters_top.sv @@
// ----------------------------------------------------------------------------
// bus_mailbox_motor_pulse_counters_top
// Bus mailbox with four motor pulse counters and an attention request line.
// ----------------------------------------------------------------------------
// Each request passes an input register and a result register; its result is
// valid in the result register once the held request moves on from the input
// register. A new request is accepted in every cycle while the result side keeps
// taking results. The rate rests on the single update of the buffer and counter
// state between those two registers.
// The user must write limits through the configuration port only while no
// request is in flight; the block itself does not enforce this.
module bus_mailbox_motor_pulse_counters_top import bmmpc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_item,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [LIMIT_BITS-1:0]   i_cfg_data
);

    logic            r_in_valid;
    t_in_item        r_in;
    logic            r_out_valid;
    t_out_item       r_out;
    t_out_item       n_out;
    logic            w_adv;
    t_buf_ctl        w_ctl;
    t_snap_view      w_view;
    logic            w_req_next;
    logic [7:0]      w_read_byte;
    logic            w_ack;
    logic [3:0][7:0] w_duty;

    // The held request moves on when the result register is free or draining.
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    bmmpc_buffers u_buffers (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_adv),
        .i_item      (r_in),
        .i_view      (w_view),
        .o_ctl       (w_ctl),
        .o_read_byte (w_read_byte),
        .o_ack       (w_ack),
        .o_duty      (w_duty)
    );

    bmmpc_counters u_counters (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_adv),
        .i_item     (r_in),
        .i_ctl      (w_ctl),
        .o_view     (w_view),
        .o_req_next (w_req_next)
    );

    // Result assembly.
    always_comb begin
        n_out.read_byte        = w_read_byte;
        n_out.ack              = w_ack;
        n_out.request_asserted = w_req_next;
        n_out.duty_a           = w_duty[0];
        n_out.duty_b           = w_duty[1];
        n_out.duty_c           = w_duty[2];
        n_out.duty_d           = w_duty[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A held request that cannot move on blocks new requests.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |-> !o_in_ready)
        else $error("input accepted while the held request is stalled");

    // A read start is always acknowledged in the result that follows.
    a_read_start_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in.req_type == REQ_READ_START)) |=> (o_out_valid && o_out_item.ack))
        else $error("read start result not acknowledged");

    // Pulse results carry no read byte and no acknowledge.
    a_pulse_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in.req_type == REQ_PULSE))
        |=> ((o_out_item.read_byte == 8'h00) && !o_out_item.ack))
        else $error("pulse result drives read byte or acknowledge");

    // Write requests never offer a read byte.
    a_write_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && ((r_in.req_type == REQ_WRITE_BYTE) || (r_in.req_type == REQ_WRITE_START)))
        |=> (o_out_item.read_byte == 8'h00))
        else $error("write result offers a read byte");

endmodule

@@ tb/tb_bus_mailbox_motor_pulse_counters_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bus_mailbox_motor_pulse_counters_top
// Self-checking bench for the bus mailbox with four motor pulse counters.
// A table of directed requests runs first. Random bus transactions follow:
// command writes, pulse bursts, reads and noise, under six sets of pulse
// limits and three patterns of idling on both channels. Every result is checked
// field by field against the table or a behavioral mailbox model kept here.
// ----------------------------------------------------------------------------
module tb_bus_mailbox_motor_pulse_counters_top;
    import bmmpc_pkg::*;

    // Code that the block leaves unused.
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // Configuration register indexes.
    localparam int CFG_LIMIT_CHAN0 = 0;
    localparam int CFG_LIMIT_CHAN1 = 1;
    localparam int CFG_LIMIT_CHAN2 = 2;
    localparam int CFG_LIMIT_CHAN3 = 3;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int DRAIN_CYCLES    = 6;
    localparam int LIMIT_CYCLES    = 400000;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item outcome;
    } stim_row_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    t_in_item                in_item   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    t_out_item               out_item;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx   = '0;
    logic [LIMIT_BITS-1:0]   cfg_data  = '0;

    // Mailbox model state.
    logic [7:0]            cmd_bytes   [BUFFER_BYTES];
    logic [7:0]            reply_bytes [BUFFER_BYTES];
    int                    wr_pos;
    int                    rd_pos;
    bit                    snap_due;
    logic [COUNT_BITS-1:0] pulse_cnt   [NUM_CHAN];
    bit                    attn_line;
    logic [LIMIT_BITS-1:0] limit_reg   [NUM_CHAN];

    t_out_item pending_replies [$];
    stim_row_t directed_rows   [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent_count    = 0;
    int result_count  = 0;
    int attn_count    = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    bus_mailbox_motor_pulse_counters_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_bus_mailbox_motor_pulse_counters_top: FAIL");
            $finish;
        end
    end

    // Result side stalls at random.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Advance the mailbox model by one request and return its result.
    function automatic t_out_item mailbox_step(input t_in_item it);
        t_out_item  r;
        logic [7:0] dir;
        int         c;
        r = '0;
        case (it.req_type)
            REQ_WRITE_START: begin
                wr_pos = 0;
                r.ack  = 1'b1;
            end
            REQ_WRITE_BYTE: begin
                // Bytes beyond the end of the command buffer are dropped.
                if (wr_pos < BUFFER_BYTES) begin
                    cmd_bytes[wr_pos] = it.data_byte;
                    wr_pos++;
                end
                r.ack = 1'b1;
            end
            REQ_STOP: begin
                r.ack = 1'b1;
            end
            REQ_READ_START: begin
                r.read_byte = reply_bytes[0];
                rd_pos      = 1;
                r.ack       = 1'b1;
            end
            REQ_READ_NEXT: begin
                // The first read-next byte of a read latches the counters.
                if (snap_due) begin
                    pulse_cnt[2] = pulse_cnt[2] >> 2;
                    pulse_cnt[3] = pulse_cnt[3] >> 2;
                    for (c = 0; c < NUM_CHAN; c++) begin
                        reply_bytes[2*c]   = pulse_cnt[c][7:0];
                        reply_bytes[2*c+1] = pulse_cnt[c][15:8];
                    end
                    snap_due = 1'b0;
                end
                if (rd_pos < BUFFER_BYTES) begin
                    r.read_byte = reply_bytes[rd_pos];
                    rd_pos++;
                    r.ack = (rd_pos != BUFFER_BYTES);
                end
            end
            REQ_READ_DONE: begin
                snap_due = 1'b1;
                r.ack    = 1'b1;
            end
            REQ_PULSE: begin
                c   = it.channel;
                dir = cmd_bytes[4 + c];
                if (dir == DIR_UP)
                    pulse_cnt[c] = pulse_cnt[c] + 1'b1;
                else if (dir == DIR_DOWN)
                    pulse_cnt[c] = pulse_cnt[c] - 1'b1;
                else if (dir == DIR_HOLD || dir == DIR_STOP)
                    attn_line = 1'b0;
                if (dir == DIR_UP && pulse_cnt[c] > limit_reg[c])
                    attn_line = 1'b1;
                if (dir == DIR_DOWN && pulse_cnt[c] < limit_reg[c])
                    attn_line = 1'b1;
            end
            default: begin
            end
        endcase
        r.request_asserted = attn_line;
        r.duty_a = cmd_bytes[0];
        r.duty_b = cmd_bytes[1];
        r.duty_c = cmd_bytes[2];
        r.duty_d = cmd_bytes[3];
        return r;
    endfunction

    function automatic t_in_item mk_item(input logic [2:0] req, input logic [7:0] data,
                                         input logic [CHAN_BITS-1:0] ch);
        t_in_item it;
        it.req_type  = req;
        it.data_byte = data;
        it.channel   = ch;
        return it;
    endfunction

    function automatic t_out_item bus_reply(input logic [7:0] rb, input logic ack,
                                            input logic attn, input logic [7:0] a,
                                            input logic [7:0] b, input logic [7:0] c,
                                            input logic [7:0] d);
        t_out_item r;
        r.read_byte        = rb;
        r.ack              = ack;
        r.request_asserted = attn;
        r.duty_a           = a;
        r.duty_b           = b;
        r.duty_c           = c;
        r.duty_d           = d;
        return r;
    endfunction

    function automatic bit sender_idles();
        return ($urandom_range(99) < send_idle_pct);
    endfunction

    task automatic add_row(input t_in_item it, input bit typed, input t_out_item outcome);
        stim_row_t row;
        row.item    = it;
        row.typed   = typed;
        row.outcome = outcome;
        directed_rows.push_back(row);
    endtask

    // Offer one request, wait for its acceptance and queue its expected result.
    task automatic push_request(input t_in_item it, input bit typed,
                                input t_out_item typed_out);
        t_out_item predicted;
        if (sender_idles()) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (sender_idles()) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = mailbox_step(it);
        pending_replies.push_back(typed ? typed_out : predicted);
        sent_count++;
    endtask

    task automatic push_random(input t_in_item it);
        push_request(it, 1'b0, '0);
    endtask

    // Hold off the sender until every expected result has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four pulse limits on consecutive cycles.
    task automatic set_limits(input logic [LIMIT_BITS-1:0] l0, input logic [LIMIT_BITS-1:0] l1,
                              input logic [LIMIT_BITS-1:0] l2, input logic [LIMIT_BITS-1:0] l3);
        logic [LIMIT_BITS-1:0] vals [NUM_CHAN];
        vals = '{l0, l1, l2, l3};
        for (int i = 0; i < NUM_CHAN; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_BITS'(CFG_LIMIT_CHAN0 + i);
            cfg_data <= vals[i];
            @(posedge clk);
            limit_reg[i] = vals[i];
        end
        cfg_we <= 1'b0;
    endtask

    // Random bus transactions, mostly well formed, until n more requests are sent.
    task automatic run_random(input int n);
        int                   target;
        int                   kind;
        int                   k;
        int                   len;
        logic [7:0]           data;
        logic [CHAN_BITS-1:0] ch;
        target = sent_count + n;
        while (sent_count < target) begin
            kind = $urandom_range(99);
            if (kind < 25) begin
                // Command write, sometimes running past the end of the buffer.
                push_random(mk_item(REQ_WRITE_START, $urandom_range(255), $urandom_range(3)));
                len = $urandom_range(10);
                for (k = 0; k < len; k++) begin
                    data = $urandom_range(255);
                    if (k >= 4 && k < 8 && $urandom_range(9) < 8) begin
                        case ($urandom_range(3))
                            0: data = DIR_STOP;
                            1: data = DIR_UP;
                            2: data = DIR_DOWN;
                            default: data = DIR_HOLD;
                        endcase
                    end
                    push_random(mk_item(REQ_WRITE_BYTE, data, $urandom_range(3)));
                end
            end else if (kind < 60) begin
                // Pulse burst, mostly on one channel.
                ch  = $urandom_range(3);
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(9) < 3) ch = $urandom_range(3);
                    push_random(mk_item(REQ_PULSE, $urandom_range(255), ch));
                end
            end else if (kind < 85) begin
                // Read, sometimes past the end, usually closed by read done.
                push_random(mk_item(REQ_READ_START, $urandom_range(255), $urandom_range(3)));
                len = $urandom_range(10);
                for (k = 0; k < len; k++)
                    push_random(mk_item(REQ_READ_NEXT, $urandom_range(255), $urandom_range(3)));
                if ($urandom_range(9) < 8)
                    push_random(mk_item(REQ_READ_DONE, $urandom_range(255), $urandom_range(3)));
            end else if (kind < 90) begin
                push_random(mk_item(REQ_STOP, $urandom_range(255), $urandom_range(3)));
            end else begin
                // Noise: any code, the unused one included.
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    push_random(mk_item($urandom_range(7), $urandom_range(255),
                                        $urandom_range(3)));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Result checker.
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            result_count++;
            if (out_item.request_asserted) attn_count++;
            if (pending_replies.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h",
                         $time, out_item);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                check_field("read_byte", want.read_byte, out_item.read_byte);
                check_field("ack", want.ack, out_item.ack);
                check_field("request_asserted", want.request_asserted,
                            out_item.request_asserted);
                check_field("duty_a", want.duty_a, out_item.duty_a);
                check_field("duty_b", want.duty_b, out_item.duty_b);
                check_field("duty_c", want.duty_c, out_item.duty_c);
                check_field("duty_d", want.duty_d, out_item.duty_d);
            end
        end
    end

    // Stimulus sequence.
    initial begin
        int phase;
        int half;

        // Model state after reset.
        for (int i = 0; i < BUFFER_BYTES; i++) begin
            cmd_bytes[i]   = '0;
            reply_bytes[i] = '0;
        end
        for (int i = 0; i < NUM_CHAN; i++) begin
            pulse_cnt[i] = '0;
            limit_reg[i] = LIMIT_RESET[i];
        end
        wr_pos    = 0;
        rd_pos    = 0;
        snap_due  = 1'b1;
        attn_line = 1'b0;

        // Directed table, run under the reset limits.
        add_row(mk_item(REQ_READ_START, 8'h00, 2'd0), 1, bus_reply(8'h00, 1, 0, 0, 0, 0, 0));
        add_row(mk_item(REQ_READ_NEXT, 8'h00, 2'd0), 1, bus_reply(8'h00, 1, 0, 0, 0, 0, 0));
        add_row(mk_item(REQ_PULSE, 8'hFF, 2'd0), 1, bus_reply(8'h00, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(REQ_UNUSED, 8'hFF, 2'd3), 1, bus_reply(8'h00, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(REQ_STOP, 8'h00, 2'd3), 1, bus_reply(8'h00, 1, 0, 0, 0, 0, 0));
        add_row(mk_item(REQ_WRITE_START, 8'hFF, 2'd0), 1, bus_reply(8'h00, 1, 0, 0, 0, 0, 0));
        add_row(mk_item(REQ_WRITE_BYTE, 8'hFF, 2'd0), 1,
                bus_reply(8'h00, 1, 0, 8'hFF, 0, 0, 0));
        add_row(mk_item(REQ_WRITE_BYTE, 8'h00, 2'd3), 1,
                bus_reply(8'h00, 1, 0, 8'hFF, 8'h00, 0, 0));
        add_row(mk_item(REQ_WRITE_BYTE, 8'h80, 2'd0), 1,
                bus_reply(8'h00, 1, 0, 8'hFF, 8'h00, 8'h80, 0));
        add_row(mk_item(REQ_WRITE_BYTE, 8'h7F, 2'd0), 1,
                bus_reply(8'h00, 1, 0, 8'hFF, 8'h00, 8'h80, 8'h7F));
        add_row(mk_item(REQ_WRITE_BYTE, DIR_UP, 2'd0), 0, '0);
        add_row(mk_item(REQ_WRITE_BYTE, DIR_DOWN, 2'd0), 0, '0);
        add_row(mk_item(REQ_WRITE_BYTE, DIR_HOLD, 2'd0), 0, '0);
        add_row(mk_item(REQ_WRITE_BYTE, 8'hFC, 2'd0), 0, '0);
        // The buffer is full, so this byte is dropped.
        add_row(mk_item(REQ_WRITE_BYTE, 8'h55, 2'd0), 1,
                bus_reply(8'h00, 1, 0, 8'hFF, 8'h00, 8'h80, 8'h7F));
        // Counting down from zero wraps around.
        add_row(mk_item(REQ_PULSE, 8'h00, 2'd1), 0, '0);
        // An unknown direction code leaves channel 3 alone.
        add_row(mk_item(REQ_PULSE, 8'h00, 2'd3), 0, '0);
        // Six up pulses take channel 0 past its limit.
        for (int i = 0; i < 6; i++)
            add_row(mk_item(REQ_PULSE, 8'h00, 2'd0), 0, '0);
        // A pulse under a hold command releases the line.
        add_row(mk_item(REQ_PULSE, 8'h00, 2'd2), 0, '0);
        add_row(mk_item(REQ_READ_DONE, 8'h00, 2'd0), 0, '0);
        add_row(mk_item(REQ_READ_START, 8'h00, 2'd0), 0, '0);
        add_row(mk_item(REQ_READ_NEXT, 8'h00, 2'd0), 0, '0);
        add_row(mk_item(REQ_READ_NEXT, 8'h00, 2'd0), 0, '0);

        // Hold reset, then release it.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            // Idling pattern: sender light, then receiver light, then none.
            if (phase < 2) begin
                send_idle_pct = 29;
                recv_idle_pct = 73;
            end else if (phase < 4) begin
                send_idle_pct = 73;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // New pulse limits, written while the block is idle.
            if (phase > 0) begin
                drain_results();
                case (phase)
                    1: set_limits('0, '0, '0, '0);
                    2: set_limits('1, '1, '1, '1);
                    3: set_limits($urandom_range(12), $urandom_range(12),
                                  $urandom_range(12), $urandom_range(12));
                    4: set_limits($urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535), $urandom_range(65535));
                    default: set_limits('0, '1, $urandom_range(12), $urandom_range(12));
                endcase
            end

            if (phase == 0) begin
                foreach (directed_rows[i])
                    push_request(directed_rows[i].item, directed_rows[i].typed,
                                 directed_rows[i].outcome);
            end

            // The sender pauses mid-phase until every result is back.
            half = ITEMS_PER_PHASE / 2;
            run_random(half);
            drain_results();
            run_random(ITEMS_PER_PHASE - half);
        end

        drain_results();
        $display("Ran %0d requests over %0d limit settings and three idling patterns.",
                 sent_count, NUM_PHASES);
        $display("Checked %0d results, %0d of them with the attention line active.",
                 result_count, attn_count);
        if (mismatches == 0) begin
            $display("tb_bus_mailbox_motor_pulse_counters_top: PASS");
        end else begin
            $display("tb_bus_mailbox_motor_pulse_counters_top: FAIL");
        end
        $finish;
    end

endmodule
